@@ design/vector_cosine_similarity_macros.svh @@
// Assertion macros used by the cosine similarity top level.
// Define ASSERT_OFF to compile every assertion away.
`ifndef VECTOR_COSINE_SIMILARITY_MACROS_SVH
`define VECTOR_COSINE_SIMILARITY_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge outside reset.
`define VCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cosine similarity: implication check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define VCS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cosine similarity: next-cycle check failed");
`else
`define VCS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define VCS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ design/vcs_pkg.sv @@
// Shared types and constants of the cosine similarity block.
// No dependencies; used by the controller, the datapath and the top level.
package vcs_pkg;

  // Accumulator and arithmetic widths.
  localparam int SUM_BITS  = 41;
  localparam int PROD_BITS = 2 * SUM_BITS;
  localparam int R_SHIFT   = 30;
  localparam int QBITS     = 32;
  localparam int DIV_BITS  = PROD_BITS + QBITS;
  localparam int OUT_BITS  = 16;
  localparam int SQ_BITS   = QBITS / 2;
  localparam int CNT_BITS  = 6;

  localparam logic [OUT_BITS-1:0] MAG_MAX = 16'd16384;
  localparam logic [QBITS-1:0]    SQ_ONE  = 32'h4000_0000;

  // Last count value of each iterative phase.
  localparam logic [CNT_BITS-1:0] MUL_LAST  = CNT_BITS'(SUM_BITS - 1);
  localparam logic [CNT_BITS-1:0] DIV_LAST  = CNT_BITS'(QBITS - 1);
  localparam logic [CNT_BITS-1:0] SQRT_LAST = CNT_BITS'(SQ_BITS - 1);

  // Controller states, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CHECK = 8'b0000_0010,
    ST_MUL   = 8'b0000_0100,
    ST_DIVI  = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_SQRTI = 8'b0010_0000,
    ST_SQRT  = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc;
    logic mul_init;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic out_load;
  } vcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_norm;
  } vcs_stat_t;

endpackage

@@ design/vcs_ctrl.sv @@
// Controller state machine of the cosine similarity block.
// Depends on vcs_pkg; drives the datapath through vcs_cmd_t.
module vcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_element,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  vcs_pkg::vcs_stat_t stat,
  output vcs_pkg::vcs_cmd_t  cmd
);
  import vcs_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state, counter and commands.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.acc = in_valid;
        if (in_valid && in_last_element) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.mul_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = stat.zero_norm ? ST_FIN : ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_DIVI;
        end
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_SQRTI;
        end
      end
      ST_SQRTI: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == SQRT_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ design/vcs_dp.sv @@
// Datapath of the cosine similarity block: accumulators, shift-add
// multipliers, restoring divider, integer square root and result register.
// Depends on vcs_pkg; commanded by vcs_ctrl.
module vcs_dp #(
  parameter int ELEMENT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic signed [ELEMENT_BITS-1:0] in_first_value,
  input  logic signed [ELEMENT_BITS-1:0] in_second_value,
  input  vcs_pkg::vcs_cmd_t              cmd,
  output vcs_pkg::vcs_stat_t             stat,
  output logic signed [vcs_pkg::OUT_BITS-1:0] out_similarity,
  output logic                           out_zero_norm
);
  import vcs_pkg::*;

  localparam int PW = 2 * ELEMENT_BITS;
  localparam int XW = ((PW > SUM_BITS) ? PW : SUM_BITS) + 1;
  localparam logic signed [SUM_BITS-1:0] DMAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] DMIN = {1'b1, {(SUM_BITS-1){1'b0}}};
  localparam logic        [SUM_BITS-1:0] NMAX = {SUM_BITS{1'b1}};

  logic signed [SUM_BITS-1:0] dot_r, dot_nxt;
  logic        [SUM_BITS-1:0] n1_r, n1_nxt, n2_r, n2_nxt;
  logic signed [PW-1:0]       prod_ab, prod_aa, prod_bb;
  logic signed [XW-1:0]       dot_ext;
  logic        [XW-1:0]       n1_ext, n2_ext;

  // Element products and saturating accumulation.
  always_comb begin
    prod_ab = in_first_value * in_second_value;
    prod_aa = in_first_value * in_first_value;
    prod_bb = in_second_value * in_second_value;
    dot_ext = XW'(dot_r) + XW'(prod_ab);
    n1_ext  = XW'(n1_r) + XW'($unsigned(prod_aa));
    n2_ext  = XW'(n2_r) + XW'($unsigned(prod_bb));
    if (dot_ext > XW'(DMAX)) begin
      dot_nxt = DMAX;
    end else if (dot_ext < XW'(DMIN)) begin
      dot_nxt = DMIN;
    end else begin
      dot_nxt = SUM_BITS'(dot_ext);
    end
    n1_nxt = (n1_ext > XW'(NMAX)) ? NMAX : SUM_BITS'(n1_ext);
    n2_nxt = (n2_ext > XW'(NMAX)) ? NMAX : SUM_BITS'(n2_ext);
  end

  // Sums clear at reset and once the result is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      dot_r <= '0;
      n1_r  <= '0;
      n2_r  <= '0;
    end else if (cmd.acc) begin
      dot_r <= dot_nxt;
      n1_r  <= n1_nxt;
      n2_r  <= n2_nxt;
    end
  end

  assign stat.zero_norm = (n1_r == '0) || (n2_r == '0);

  // Shift-add multipliers: norm product and squared dot magnitude.
  logic [SUM_BITS-1:0]  absd;
  logic [PROD_BITS-1:0] p_acc_r, p_mc_r, s_acc_r, s_mc_r;
  logic [SUM_BITS-1:0]  p_ml_r, s_ml_r;

  assign absd = dot_r[SUM_BITS-1] ? SUM_BITS'(-dot_r) : SUM_BITS'(dot_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_init) begin
      p_acc_r <= '0;
      p_mc_r  <= PROD_BITS'(n1_r);
      p_ml_r  <= n2_r;
      s_acc_r <= '0;
      s_mc_r  <= PROD_BITS'(absd);
      s_ml_r  <= absd;
    end else if (cmd.mul_step) begin
      if (p_ml_r[0]) begin
        p_acc_r <= p_acc_r + p_mc_r;
      end
      if (s_ml_r[0]) begin
        s_acc_r <= s_acc_r + s_mc_r;
      end
      p_mc_r <= p_mc_r << 1;
      p_ml_r <= p_ml_r >> 1;
      s_mc_r <= s_mc_r << 1;
      s_ml_r <= s_ml_r >> 1;
    end
  end

  // Restoring division of dot^2 * 2^30 by the norm product.
  logic [DIV_BITS-1:0] rem_r, dv_r, r_ext, p_top;
  logic [QBITS-1:0]    q_r;
  logic                ovf_r;

  assign r_ext = DIV_BITS'(s_acc_r) << R_SHIFT;
  assign p_top = DIV_BITS'(p_acc_r) << QBITS;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= r_ext;
      dv_r  <= DIV_BITS'(p_acc_r) << (QBITS - 1);
      ovf_r <= (r_ext >= p_top);
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= dv_r) begin
        rem_r <= rem_r - dv_r;
        q_r   <= {q_r[QBITS-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QBITS-2:0], 1'b0};
      end
      dv_r <= dv_r >> 1;
    end
  end

  // Bit-by-bit integer square root of the saturated quotient.
  logic [QBITS-1:0] op_r, res_r, one_r;
  logic [QBITS:0]   trial;

  assign trial = {1'b0, res_r} + {1'b0, one_r};

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      op_r  <= ovf_r ? '1 : q_r;
      res_r <= '0;
      one_r <= SQ_ONE;
    end else if (cmd.sqrt_step) begin
      if ({1'b0, op_r} >= trial) begin
        op_r  <= op_r - QBITS'(trial);
        res_r <= (res_r >> 1) + one_r;
      end else begin
        res_r <= res_r >> 1;
      end
      one_r <= one_r >> 2;
    end
  end

  // Rounded magnitude, capped at one, with the sign of the dot product.
  logic [SQ_BITS:0]    rnd;
  logic [OUT_BITS-1:0] mag;
  logic [OUT_BITS-1:0] sim_r;
  logic                zn_r;

  always_comb begin
    rnd = (SQ_BITS+1)'(res_r[SQ_BITS-1:0]) + 1'b1;
    mag = OUT_BITS'(rnd >> 1);
    if (mag > MAG_MAX) begin
      mag = MAG_MAX;
    end
    if (stat.zero_norm) begin
      mag = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sim_r <= dot_r[SUM_BITS-1] ? (~mag + 1'b1) : mag;
      zn_r  <= stat.zero_norm;
    end
  end

  assign out_similarity = sim_r;
  assign out_zero_norm  = zn_r;

endmodule

@@ design/vector_cosine_similarity.sv @@
// Cosine similarity of two streamed vectors.
// Depends on vcs_pkg, vcs_ctrl, vcs_dp and the assertion macro header.
//
// Usage: element pairs (signed Q1.15) arrive on the in_ channel, one request
// per cycle while in_stall is low. The request with in_last_element high
// closes the vector. The block then computes dot / sqrt(n1 * n2), rounded to
// nearest as signed Q2.14, and offers it on the out_ channel with
// out_zero_norm, which is set (and the similarity 0) when a norm is zero.
// Throughput: one element pair per cycle inside a vector. After the last
// pair, in_stall stays high while the finish phase runs shift-add
// multiplication, restoring division and square root, plus setup steps;
// a zero norm skips all three. The sums are cleared when the result is
// loaded, and the next vector may stream in while that result waits.
// If the receiver stalls, the result holds and the next finished vector
// waits in the final step until the output register is free.
// Reset clears the sums, the controller and the output valid.
module vector_cosine_similarity #(
  parameter int ELEMENT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ELEMENT_BITS-1:0]      in_first_value,
  input  logic signed [ELEMENT_BITS-1:0]      in_second_value,
  input  logic                                in_last_element,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [vcs_pkg::OUT_BITS-1:0] out_similarity,
  output logic                                out_zero_norm
);
  import vcs_pkg::*;
  `include "vector_cosine_similarity_macros.svh"

  vcs_cmd_t  cmd;
  vcs_stat_t stat;
  logic      sim_in_range;

  // Sequencing of the accumulate and finish phases.
  vcs_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last_element (in_last_element),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .stat            (stat),
    .cmd             (cmd)
  );

  // Arithmetic and result register.
  vcs_dp #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_first_value  (in_first_value),
    .in_second_value (in_second_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_similarity  (out_similarity),
    .out_zero_norm   (out_zero_norm)
  );

  // The similarity lies between minus one and one in Q2.14.
  assign sim_in_range = (out_similarity <= 16'sd16384) && (out_similarity >= -16'sd16384);

  // A zero-norm result carries a zero similarity.
  `VCS_ASSERT_IMP(a_zero_result, clk, rst_n, out_valid && out_zero_norm, out_similarity == '0)
  // Results never leave the range of minus one to one.
  `VCS_ASSERT_IMP(a_range, clk, rst_n, out_valid, sim_in_range)
  // Closing a vector stops intake for the finish phase.
  `VCS_ASSERT_NXT(a_last_stalls, clk, rst_n, in_valid && !in_stall && in_last_element, in_stall)

endmodule

@@ test/tb_vector_cosine_similarity.sv @@
// Self-checking testbench for vector_cosine_similarity.
// It streams element pairs and predicts each cosine result with exact wide integers.
// It depends only on vcs_pkg and the block itself.
`timescale 1ns / 100ps

module tb_vector_cosine_similarity;
  import vcs_pkg::*;

  localparam int          CYCLE_LIMIT = 600000;
  localparam longint      DOT_MAX     = (64'sd1 <<< (SUM_BITS - 1)) - 1;
  localparam longint      DOT_MIN     = -DOT_MAX - 1;
  localparam longint      NORM_MAX    = (64'sd1 <<< SUM_BITS) - 1;
  localparam int          QUIET_TAIL  = 120;

  typedef struct {
    logic signed [15:0] first;
    logic signed [15:0] second;
    logic               last;
    logic               drain;
  } pair_req_t;

  typedef struct {
    logic signed [OUT_BITS-1:0] similarity;
    logic                       zero_norm;
  } cosine_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_first_value = '0;
  logic signed [15:0] in_second_value = '0;
  logic in_last_element = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_BITS-1:0] out_similarity;
  logic out_zero_norm;

  pair_req_t pending_pairs[$];
  cosine_t   expected_cosines[$];
  int        error_count = 0;
  int        cycle_count = 0;
  bit        quiet_tail = 1'b0;

  // Running sums of the predictor.
  longint dot_acc = 0;
  longint norm1_acc = 0;
  longint norm2_acc = 0;

  vector_cosine_similarity dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_first_value(in_first_value),
    .in_second_value(in_second_value),
    .in_last_element(in_last_element),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_similarity(out_similarity),
    .out_zero_norm(out_zero_norm)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Accumulate one pair with saturation; on the last pair, queue the rounded cosine.
  task automatic accumulate_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                                 input logic last);
    longint     av, bv, sum;
    bit [127:0] base, rhs, lhs, odd;
    longint     lo, hi, mid, absd;
    cosine_t    res;
    av = a;
    bv = b;
    sum = dot_acc + av * bv;
    dot_acc = (sum > DOT_MAX) ? DOT_MAX : ((sum < DOT_MIN) ? DOT_MIN : sum);
    sum = norm1_acc + av * av;
    norm1_acc = (sum > NORM_MAX) ? NORM_MAX : sum;
    sum = norm2_acc + bv * bv;
    norm2_acc = (sum > NORM_MAX) ? NORM_MAX : sum;
    if (last) begin
      if (norm1_acc == 0 || norm2_acc == 0) begin
        res.similarity = '0;
        res.zero_norm = 1'b1;
      end else begin
        absd = (dot_acc < 0) ? -dot_acc : dot_acc;
        base = 128'(norm1_acc) * 128'(norm2_acc);
        rhs = (128'(absd) * 128'(absd)) << 30;
        lo = 0;
        hi = 16384;
        // Largest magnitude whose lower rounding edge is still at or below the exact value.
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          odd = 128'(2 * mid - 1);
          lhs = base * odd * odd;
          if (lhs <= rhs) lo = mid;
          else hi = mid - 1;
        end
        res.similarity = (dot_acc < 0) ? OUT_BITS'(-lo) : OUT_BITS'(lo);
        res.zero_norm = 1'b0;
      end
      expected_cosines.push_back(res);
      dot_acc = 0;
      norm1_acc = 0;
      norm2_acc = 0;
    end
  endtask

  // Request driver: takes pairs from the pending queue, with random idle bursts.
  int send_gap = 0;
  int send_calm = 0;
  always @(posedge clk) begin : drive_pairs
    pair_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        accumulate_pair(in_first_value, in_second_value, in_last_element);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0 &&
                     !(pending_pairs[0].drain && expected_cosines.size() != 0)) begin
          nxt = pending_pairs.pop_front();
          in_valid <= 1'b1;
          in_first_value <= nxt.first;
          in_second_value <= nxt.second;
          in_last_element <= nxt.last;
          if (send_calm > 0) send_calm <= send_calm - 1;
          else if ($urandom_range(0, 60) == 0) send_calm <= 40;
          else if (!quiet_tail && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
      quiet_tail <= pending_pairs.size() < QUIET_TAIL;
    end
  end

  // Result monitor: random stall bursts and field-by-field comparison.
  int stall_left = 0;
  always @(posedge clk) begin : watch_results
    cosine_t exp_res;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_cosines.size() == 0) begin
          $display("%0t: unexpected result similarity=%0d zero_norm=%0b",
                   $time, out_similarity, out_zero_norm);
          error_count <= error_count + 1;
        end else begin
          exp_res = expected_cosines.pop_front();
          if (exp_res.similarity !== out_similarity ||
              exp_res.zero_norm !== out_zero_norm) begin
            $display("%0t: mismatch expected similarity=%0d zero_norm=%0b, got %0d %0b",
                     $time, exp_res.similarity, exp_res.zero_norm,
                     out_similarity, out_zero_norm);
            error_count <= error_count + 1;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_pair(input int a, input int b, input bit last, input bit drain = 1'b0);
    pair_req_t p;
    p.first = 16'(a);
    p.second = 16'(b);
    p.last = last;
    p.drain = drain;
    pending_pairs.push_back(p);
  endtask

  // One random vector; the style picks how the two vectors relate.
  task automatic add_vector(input int len, input bit drain);
    int style, a, b;
    style = $urandom_range(0, 7);
    for (int i = 0; i < len; i++) begin
      a = $urandom_range(0, 65535) - 32768;
      b = $urandom_range(0, 65535) - 32768;
      case (style)
        1: b = a;
        2: b = (a == -32768) ? 32767 : -a;
        3: begin a = a / 512; b = b / 512; end
        4: begin a = $urandom_range(0, 1) ? 32767 : -32768;
                 b = $urandom_range(0, 1) ? 32767 : -32768; end
        5: a = 0;
        6: b = $urandom_range(0, 3) == 0 ? 0 : b / 4096;
        default: ;
      endcase
      add_pair(a, b, i == len - 1, drain && i == 0);
    end
  endtask

  initial begin
    int sent;
    // Directed: extremes, zero norms and short multi-element vectors.
    add_pair(32767, 32767, 1'b1);
    add_pair(-32768, -32768, 1'b1);
    add_pair(32767, -32768, 1'b1);
    add_pair(-32768, 32767, 1'b1);
    add_pair(0, 5, 1'b1);
    add_pair(5, 0, 1'b1);
    add_pair(0, 0, 1'b1);
    add_pair(1, -1, 1'b1);
    add_pair(3, 4, 1'b0);
    add_pair(4, -3, 1'b1);
    add_pair(1, 2, 1'b0);
    add_pair(2, 1, 1'b0);
    add_pair(-1, 0, 1'b1);
    add_pair(0, 0, 1'b0);
    add_pair(0, 7, 1'b1);
    add_pair(-32768, 0, 1'b0);
    add_pair(0, -32768, 1'b1, 1'b1);

    // Random vectors, mostly short, a few long.
    sent = 0;
    while (sent < 880) begin
      int len;
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 128) : $urandom_range(1, 12);
      add_vector(len, $urandom_range(0, 30) == 0);
      sent += len;
    end

    // A few short vectors at the end.
    for (int i = 0; i < 6; i++) add_vector($urandom_range(1, 6), 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_pairs.size() == 0);
    @(posedge clk);
    wait (!in_valid && expected_cosines.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_cosines.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ vector_cosine_similarity.f @@
+incdir+design
design/vcs_pkg.sv
design/vcs_ctrl.sv
design/vcs_dp.sv
design/vector_cosine_similarity.sv
test/tb_vector_cosine_similarity.sv
